// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define SM3_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now, consequent in the cycle after
`define SM3_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  vbytes_t;
  typedef logic [2:0]  idx_t;
  typedef logic [3:0]  wpos_t;
  typedef logic [5:0]  rnd_t;

  localparam word_t      TJ_LOW   = 32'h79cc4519;
  localparam word_t      TJ_HIGH  = 32'h7a879d8a;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam word_t      SM3_IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam wpos_t LAST_POS = 4'd15;
  localparam wpos_t LEN_POS  = 4'd14;
  localparam rnd_t  LAST_RND = 6'd63;
  localparam idx_t  LAST_IDX = 3'd7;
  localparam vbytes_t FULL_BYTES = 3'd4;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN_HI,
    S_LEN_LO,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } ctrl_state_e;

  // source of a word shifted into the block buffer
  typedef enum logic [2:0] {
    PS_DATA,
    PS_TAIL,
    PS_PAD80,
    PS_ZERO,
    PS_LEN_HI,
    PS_LEN_LO
  } push_sel_e;

  typedef struct packed {
    logic      push;
    push_sel_e push_sel;
    logic      len_add;
    logic      load;
    logic      round;
    logic      fold;
    logic      emit;
    idx_t      out_idx;
    logic      reinit;
  } sm3_cmd_t;

  typedef struct packed {
    wpos_t wp;
    logic  round_last;
    logic  out_room;
  } sm3_stat_t;

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // final partial word: keep the valid bytes, then the 0x80 marker, then zeros
  function automatic word_t pad_tail(word_t d, logic [1:0] nb);
    word_t r;
    case (nb)
      2'd0:    r = {PAD_BYTE, 24'h0};
      2'd1:    r = {d[31:24], PAD_BYTE, 16'h0};
      2'd2:    r = {d[31:16], PAD_BYTE, 8'h0};
      default: r = {d[31:8], PAD_BYTE};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sm3_in_if.sv =====
// ----------------------------------------------------------------------------
// sm3_in_if
// Message word channel: valid/ready handshake with word payload.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  import sm3_pkg::*;

  logic    valid;
  logic    ready;
  word_t   data_word;
  vbytes_t valid_bytes;
  logic    final_word;

  modport source (output valid, data_word, valid_bytes, final_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

// ===== sv/sm3_out_if.sv =====
// ----------------------------------------------------------------------------
// sm3_out_if
// Digest word channel: valid/ready handshake with digest payload.
// ----------------------------------------------------------------------------
interface sm3_out_if;
  import sm3_pkg::*;

  logic  valid;
  logic  ready;
  word_t digest_word;
  idx_t  digest_index;
  logic  digest_end;

  modport source (output valid, digest_word, digest_index, digest_end, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_end, output ready);
endinterface

// ===== sv/sm3_datapath.sv =====
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer, message expansion window, round registers, chaining value,
// bit length counter and digest output register.
// ----------------------------------------------------------------------------
module sm3_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm3_pkg::sm3_cmd_t cmd_i,
  output sm3_pkg::sm3_stat_t stat_o,
  input  sm3_pkg::word_t    data_word_i,
  input  sm3_pkg::vbytes_t  valid_bytes_i,
  input  logic              final_word_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output sm3_pkg::word_t    digest_word_o,
  output sm3_pkg::idx_t     digest_index_o,
  output logic              digest_end_o
);
  import sm3_pkg::*;

  word_t       blk_q [16];
  word_t       win_q [16];
  word_t       rr_q  [8];
  word_t       chain_q [8];
  logic [63:0] bitlen_q;
  wpos_t       wp_q;
  rnd_t        rnd_q;
  logic        out_valid_q;
  word_t       out_word_q;
  idx_t        out_idx_q;
  logic        out_end_q;

  word_t       push_word;
  logic [5:0]  len_inc;
  vbytes_t     nb_sat;
  word_t       a, b, c, d, e, f, g, h;
  word_t       a12, tj, ff, gg, ss1, ss2, tt1, tt2, w_new;
  logic        out_room;

  // word entering the block buffer
  always_comb begin
    unique case (cmd_i.push_sel)
      PS_DATA:   push_word = data_word_i;
      PS_TAIL:   push_word = pad_tail(data_word_i, valid_bytes_i[1:0]);
      PS_PAD80:  push_word = {PAD_BYTE, 24'h0};
      PS_ZERO:   push_word = '0;
      PS_LEN_HI: push_word = bitlen_q[63:32];
      PS_LEN_LO: push_word = bitlen_q[31:0];
      default:   push_word = '0;
    endcase
  end

  // bits added by an accepted word; count saturates at four bytes
  always_comb begin
    nb_sat  = (valid_bytes_i > FULL_BYTES) ? FULL_BYTES : valid_bytes_i;
    len_inc = final_word_i ? {nb_sat, 3'b000} : 6'd32;
  end

  // one compression round
  always_comb begin
    a = rr_q[0]; b = rr_q[1]; c = rr_q[2]; d = rr_q[3];
    e = rr_q[4]; f = rr_q[5]; g = rr_q[6]; h = rr_q[7];
    a12 = rotl(a, 5'd12);
    if (rnd_q[5:4] == 2'b00) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
      tj = TJ_LOW;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
      tj = TJ_HIGH;
    end
    ss1 = rotl(a12 + e + rotl(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + d + ss2 + (win_q[0] ^ win_q[4]);
    tt2 = gg + h + ss1 + win_q[0];
    // W[j+16] from the rolling window
    w_new = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15)) ^
            rotl(win_q[3], 5'd7) ^ win_q[10];
  end

  assign out_room = !out_valid_q || out_ready_i;

  // control counters, round registers and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitlen_q    <= '0;
      wp_q        <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= SM3_IV[i];
        rr_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.push) wp_q <= wp_q + 4'd1;
      if (cmd_i.reinit) begin
        bitlen_q <= '0;
      end else if (cmd_i.len_add) begin
        bitlen_q <= bitlen_q + {58'd0, len_inc};
      end
      if (cmd_i.load) begin
        rnd_q <= '0;
        for (int i = 0; i < 8; i++) rr_q[i] <= chain_q[i];
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 6'd1;
        rr_q[0] <= tt1;
        rr_q[1] <= a;
        rr_q[2] <= rotl(b, 5'd9);
        rr_q[3] <= c;
        rr_q[4] <= perm0(tt2);
        rr_q[5] <= e;
        rr_q[6] <= rotl(f, 5'd19);
        rr_q[7] <= g;
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= SM3_IV[i];
      end else if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ rr_q[i];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // block buffer and expansion window shift lines, digest payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
      blk_q[15] <= push_word;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) win_q[i] <= blk_q[i];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_new;
    end
    if (cmd_i.emit) begin
      out_word_q <= chain_q[cmd_i.out_idx];
      out_idx_q  <= cmd_i.out_idx;
      out_end_q  <= (cmd_i.out_idx == LAST_IDX);
    end
  end

  assign stat_o.wp         = wp_q;
  assign stat_o.round_last = (rnd_q == LAST_RND);
  assign stat_o.out_room   = out_room;

  assign out_valid_o    = out_valid_q;
  assign digest_word_o  = out_word_q;
  assign digest_index_o = out_idx_q;
  assign digest_end_o   = out_end_q;

endmodule

// ===== sv/sm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: word intake, hardware padding, block compression and digest
// readout, driving the datapath through one command word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_final_i,
  input  sm3_pkg::vbytes_t   in_valid_bytes_i,
  output logic               in_ready_o,
  output sm3_pkg::sm3_cmd_t  cmd_o,
  input  sm3_pkg::sm3_stat_t stat_i
);
  import sm3_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;
  idx_t        cnt_q, cnt_d;
  ctrl_state_e follow;
  logic        accept;
  logic        full;

  // state, return point and digest word counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // the word pushed this cycle completes the block
  assign full       = (stat_i.wp == LAST_POS);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.push_sel = PS_DATA;
    cmd_o.out_idx  = cnt_q;
    follow  = S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.push    = 1'b1;
          cmd_o.len_add = 1'b1;
          if (!in_final_i) begin
            follow = S_IDLE;
          end else if (in_valid_bytes_i >= FULL_BYTES) begin
            follow = S_PAD80;
          end else begin
            cmd_o.push_sel = PS_TAIL;
            follow = S_ZERO;
          end
          if (full) begin
            state_d = S_LOAD;
            ret_d   = follow;
          end else begin
            state_d = follow;
          end
        end
      end
      S_PAD80: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PS_PAD80;
        if (full) begin
          state_d = S_LOAD;
          ret_d   = S_ZERO;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        // zero fill up to the length field, or to the block end
        if (stat_i.wp == LEN_POS) begin
          state_d = S_LEN_HI;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = PS_ZERO;
          if (full) begin
            state_d = S_LOAD;
            ret_d   = S_ZERO;
          end
        end
      end
      S_LEN_HI: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PS_LEN_HI;
        state_d        = S_LEN_LO;
      end
      S_LEN_LO: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PS_LEN_LO;
        state_d        = S_LOAD;
        ret_d          = S_OUT;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        if (stat_i.round_last) state_d = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      S_OUT: begin
        if (stat_i.out_room) begin
          cmd_o.emit = 1'b1;
          cnt_d      = cnt_q + 3'd1;
          if (cnt_q == LAST_IDX) begin
            cmd_o.reinit = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `SM3_ASSERT_NEXT(a_round_to_fold, state_q == S_ROUND && stat_i.round_last, state_q == S_FOLD, "compression did not end after the last round")
  `SM3_ASSERT(a_load_on_wrap, !cmd_o.load || stat_i.wp == 4'd0, "block loaded while the buffer was partly filled")
  `SM3_ASSERT(a_len_lo_at_end, state_q != S_LEN_LO || stat_i.wp == LAST_POS, "low length word not at the block end")
  `SM3_ASSERT(a_emit_room, !cmd_o.emit || stat_i.out_room, "digest word issued into a full output register")

endmodule

// ===== sv/sm3_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// SM3 hash engine: message words in, padded and compressed in hardware,
// 256-bit digest out as eight words.
//
//   channel  dir  payload                                  notes
//   msg_i    in   data_word, valid_bytes, final_word        word per handshake
//   dig_o    out  digest_word, digest_index, digest_end     eight words/msg
//
// A non-final word is pushed into the block buffer; every 16th word starts a
// compression (load, 64 rounds of the shared round unit, fold into the chain),
// during which no word is taken. A final word adds the padding words, one or
// two compressions and eight readout words; the next message is taken while
// the last digest word still waits in the output register. No clearing pass
// after reset. The output register holds its word while dig_o.ready is low.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  sm3_in_if.sink           msg_i,
  sm3_out_if.source        dig_o
);
  import sm3_pkg::*;

  sm3_cmd_t  cmd;
  sm3_stat_t stat;

  sm3_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (msg_i.valid),
    .in_final_i       (msg_i.final_word),
    .in_valid_bytes_i (msg_i.valid_bytes),
    .in_ready_o       (msg_i.ready),
    .cmd_o            (cmd),
    .stat_i           (stat)
  );

  sm3_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .data_word_i    (msg_i.data_word),
    .valid_bytes_i  (msg_i.valid_bytes),
    .final_word_i   (msg_i.final_word),
    .out_ready_i    (dig_o.ready),
    .out_valid_o    (dig_o.valid),
    .digest_word_o  (dig_o.digest_word),
    .digest_index_o (dig_o.digest_index),
    .digest_end_o   (dig_o.digest_end)
  );

endmodule
